FILE: hdl/lruoc_pkg.sv
// Package: types, codes and defaults for the LRU object cache table.
package lruoc_pkg;

  localparam int DefaultEntries = 5;
  localparam int SlotW          = 6;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] texture_pair;
    logic [31:0] fog;
    logic        stretch;
    logic [15:0] handle;
    logic [30:0] last_used;
  } entry_t;

endpackage

FILE: hdl/lruoc_req_if.sv
// Request channel interface of the LRU object cache table.
interface lruoc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  kind;
  logic [15:0] first_texture;
  logic [15:0] second_texture;
  logic [31:0] fog_color;
  logic        stretch;
  logic [30:0] now_ms;
  logic [15:0] new_handle;

  modport source (
    output valid, operation, kind, first_texture, second_texture, fog_color, stretch,
           now_ms, new_handle,
    input  ready
  );
  modport sink (
    input  valid, operation, kind, first_texture, second_texture, fog_color, stretch,
           now_ms, new_handle,
    output ready
  );
endinterface

FILE: hdl/lruoc_rsp_if.sv
// Result channel interface of the LRU object cache table.
interface lruoc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [5:0]  slot;
  logic [15:0] found_handle;
  logic        evicted;
  logic [15:0] evicted_handle;

  modport source (
    output valid, hit, slot, found_handle, evicted, evicted_handle,
    input  ready
  );
  modport sink (
    input  valid, hit, slot, found_handle, evicted, evicted_handle,
    output ready
  );
endinterface

FILE: hdl/lruoc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
module lruoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lru_object_cache_table_core.sv
// Top level of the LRU object cache table: sequencer around the entry RAM.
//
// Usage: requests arrive on req (valid/ready); one result per request leaves
// on rsp (valid/ready). A lookup scans the entries in index order through the
// entry RAM, one read per cycle, and on a hit writes back the new last-used
// time. An insert takes the lowest free slot from the valid flops; when all
// are valid it scans every entry for the oldest time and overwrites it.
// Clear drops all valid bits when the request is accepted.
// The next request is taken in the cycle after the result is loaded into the
// output register: one request is handled at a time, and a new one is not
// accepted until the sequencer is back in idle.
// Reset clears all valid bits and the sequencer; RAM contents need no reset.
// A stalled result stays in the output register; the next request is still
// taken and processed, and its result waits until the register frees up.
module lru_object_cache_table_core
  import lruoc_pkg::*;
#(
  parameter int ENTRIES = DefaultEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lruoc_req_if.sink   req,
  lruoc_rsp_if.source rsp
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  state_e             state_q, state_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               chk_q, chk_d;
  logic [AW-1:0]      chk_idx_q, chk_idx_d;
  logic [AW-1:0]      target_q, target_d;
  logic [AW-1:0]      best_idx_q, best_idx_d;
  logic [30:0]        best_time_q, best_time_d;
  logic [15:0]        best_handle_q, best_handle_d;

  logic [1:0]  op_q, op_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] pair_q, pair_d;
  logic [31:0] fog_q, fog_d;
  logic        str_q, str_d;
  logic [30:0] now_q, now_d;
  logic [15:0] handle_q, handle_d;

  logic             res_hit_q, res_hit_d;
  logic [SlotW-1:0] res_slot_q, res_slot_d;
  logic [15:0]      res_found_q, res_found_d;
  logic             res_evicted_q, res_evicted_d;
  logic [15:0]      res_evh_q, res_evh_d;

  logic             out_valid_q, out_valid_d;
  logic             out_hit_q, out_hit_d;
  logic [SlotW-1:0] out_slot_q, out_slot_d;
  logic [15:0]      out_found_q, out_found_d;
  logic             out_evicted_q, out_evicted_d;
  logic [15:0]      out_evh_q, out_evh_d;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_wdata;
  entry_t        ent;

  logic          have_free;
  logic [AW-1:0] free_idx;
  logic          match;
  logic          older;
  logic          last;
  logic          req_fire;

  lruoc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (target_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ent)
  );

  assign req.ready = (state_q == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        have_free = 1'b1;
        free_idx  = AW'(i);
      end
    end
  end

  assign match = valid_q[chk_idx_q] && (ent.kind == kind_q) && (ent.texture_pair == pair_q) &&
                 (ent.fog == fog_q) && (ent.stretch == str_q);
  assign older = (chk_idx_q == '0) || (ent.last_used < best_time_q);
  assign last  = (chk_idx_q == AW'(ENTRIES - 1));

  always_comb begin
    ram_wdata.kind         = kind_q;
    ram_wdata.texture_pair = pair_q;
    ram_wdata.fog          = fog_q;
    ram_wdata.stretch      = str_q;
    ram_wdata.handle       = (op_q == OP_INSERT) ? handle_q : res_found_q;
    ram_wdata.last_used    = now_q;
  end

  always_comb begin
    state_d       = state_q;
    valid_d       = valid_q;
    idx_d         = idx_q;
    chk_d         = chk_q;
    chk_idx_d     = chk_idx_q;
    target_d      = target_q;
    best_idx_d    = best_idx_q;
    best_time_d   = best_time_q;
    best_handle_d = best_handle_q;
    op_d          = op_q;
    kind_d        = kind_q;
    pair_d        = pair_q;
    fog_d         = fog_q;
    str_d         = str_q;
    now_d         = now_q;
    handle_d      = handle_q;
    res_hit_d     = res_hit_q;
    res_slot_d    = res_slot_q;
    res_found_d   = res_found_q;
    res_evicted_d = res_evicted_q;
    res_evh_d     = res_evh_q;
    out_valid_d   = out_valid_q;
    out_hit_d     = out_hit_q;
    out_slot_d    = out_slot_q;
    out_found_d   = out_found_q;
    out_evicted_d = out_evicted_q;
    out_evh_d     = out_evh_q;
    ram_we        = 1'b0;
    ram_raddr     = idx_q[AW-1:0];

    if (out_valid_q && rsp.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d          = req.operation;
          kind_d        = req.kind;
          pair_d        = {req.second_texture, req.first_texture};
          fog_d         = req.fog_color;
          str_d         = req.stretch;
          now_d         = req.now_ms;
          handle_d      = req.new_handle;
          res_hit_d     = 1'b0;
          res_slot_d    = '0;
          res_found_d   = '0;
          res_evicted_d = 1'b0;
          res_evh_d     = '0;
          idx_d         = '0;
          chk_d         = 1'b0;
          case (req.operation)
            OP_LOOKUP: state_d = ST_SCAN;
            OP_INSERT: begin
              if (have_free) begin
                target_d = free_idx;
                state_d  = ST_WRITE;
              end else begin
                state_d = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              valid_d = '0;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (chk_q) begin
          if (op_q == OP_LOOKUP) begin
            if (match) begin
              res_hit_d   = 1'b1;
              res_slot_d  = SlotW'(chk_idx_q);
              res_found_d = ent.handle;
              target_d    = chk_idx_q;
              state_d     = ST_WRITE;
            end else if (last) begin
              state_d = ST_DONE;
            end
          end else begin
            if (older) begin
              best_idx_d    = chk_idx_q;
              best_time_d   = ent.last_used;
              best_handle_d = ent.handle;
            end
            if (last) begin
              target_d      = older ? chk_idx_q : best_idx_q;
              res_evicted_d = 1'b1;
              res_evh_d     = older ? ent.handle : best_handle_q;
              state_d       = ST_WRITE;
            end
          end
        end
        if ((state_d == ST_SCAN) && (idx_q < CW'(ENTRIES))) begin
          chk_d     = 1'b1;
          chk_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end else begin
          chk_d = 1'b0;
        end
      end
      ST_WRITE: begin
        ram_we            = 1'b1;
        valid_d[target_q] = 1'b1;
        res_slot_d        = SlotW'(target_q);
        state_d           = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d   = 1'b1;
          out_hit_d     = res_hit_q;
          out_slot_d    = res_slot_q;
          out_found_d   = res_found_q;
          out_evicted_d = res_evicted_q;
          out_evh_d     = res_evh_q;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    chk_idx_q     <= chk_idx_d;
    target_q      <= target_d;
    best_idx_q    <= best_idx_d;
    best_time_q   <= best_time_d;
    best_handle_q <= best_handle_d;
    op_q          <= op_d;
    kind_q        <= kind_d;
    pair_q        <= pair_d;
    fog_q         <= fog_d;
    str_q         <= str_d;
    now_q         <= now_d;
    handle_q      <= handle_d;
    res_hit_q     <= res_hit_d;
    res_slot_q    <= res_slot_d;
    res_found_q   <= res_found_d;
    res_evicted_q <= res_evicted_d;
    res_evh_q     <= res_evh_d;
    out_hit_q     <= out_hit_d;
    out_slot_q    <= out_slot_d;
    out_found_q   <= out_found_d;
    out_evicted_q <= out_evicted_d;
    out_evh_q     <= out_evh_d;
  end

  assign rsp.valid          = out_valid_q;
  assign rsp.hit            = out_hit_q;
  assign rsp.slot           = out_slot_q;
  assign rsp.found_handle   = out_found_q;
  assign rsp.evicted        = out_evicted_q;
  assign rsp.evicted_handle = out_evh_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after a request");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> valid_q[$past(target_q)])
    else $error("written entry not marked valid");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.hit) |-> !rsp.evicted)
    else $error("result reports hit and eviction together");

  a_miss_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.hit) |-> (rsp.found_handle == '0))
    else $error("found handle nonzero without a hit");

endmodule
